/* rtl/sobel_pkg.sv */
// Shared types and constants of the Sobel edge threshold block.
package sobel_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int THR_W      = 8;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int ROW_W      = 13;
    localparam int KERNEL     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Register values after reset
    localparam int FRAME_WIDTH_RST    = 640;
    localparam int FRAME_HEIGHT_RST   = 480;
    localparam int EDGE_THRESHOLD_RST = 128;

    // Result codes
    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    // What an accepted request does to the window and the line stores
    typedef enum logic [1:0] {
        KIND_FIRST,   // pixel of the top row: replicated upward
        KIND_INNER,   // pixel of a later row
        KIND_FLUSH,   // padding below the frame: bottom row replicated
        KIND_FINAL    // closes the frame with its last pixel
    } kind_t;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, index 0 is the oldest row
    typedef pix_t [KERNEL-1:0] col_t;

    // Pair of line store entries at one column
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_pair_t;

    // Decoded request handed from the position tracker to the window
    typedef struct packed {
        kind_t kind;
        logic  emit_prev;  // close the previous row's last pixel
        logic  emit_cur;   // complete the pixel left of this column
        logic  wide;       // frame is at least two pixels wide
        logic  col_ge2;    // column has two columns to its left
        pix_t  pixel;
    } item_t;

    // Neighbourhood of one output pixel
    typedef struct packed {
        col_t left;
        col_t mid;
        col_t right;
        logic last;
    } win_item_t;

endpackage

/* rtl/sobel_if.sv */
// Stream interfaces for pixel requests and edge results.
interface sobel_pix_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [sobel_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface sobel_res_if;
    logic                     valid;
    logic                     ready;
    logic [sobel_pkg::PIX_W-1:0] edge_out;
    logic                     frame_last;

    modport source (output valid, output edge_out, output frame_last, input ready);
    modport sink   (input valid, input edge_out, input frame_last, output ready);
endinterface

/* rtl/sobel_ctrl.sv */
// Position tracker: column and row counters and request decoding.
module sobel_ctrl #(
    parameter int COL_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          action,
    input  logic [sobel_pkg::PIX_W-1:0]   pixel_in,
    input  logic [COL_W-1:0]              width_last,
    input  logic [sobel_pkg::FH_W-1:0]    height,
    output logic                          load,
    output logic [COL_W-1:0]              col,
    output sobel_pkg::item_t              item
);

    logic [COL_W-1:0]             col_reg;
    logic [COL_W-1:0]             col_next;
    logic [sobel_pkg::ROW_W-1:0]  row_reg;
    logic [sobel_pkg::ROW_W-1:0]  row_next;
    logic [sobel_pkg::ROW_W-1:0]  height_x;
    logic                         flushing;
    logic                         final_item;
    logic                         drop;
    logic                         row_end;

    // Decode the request against the current position
    always_comb
    begin
        height_x   = {1'b0, height};
        flushing   = (row_reg >= height_x);
        final_item = (row_reg > height_x);
        drop       = !flushing && action;
        col        = (col_reg > width_last) ? width_last : col_reg;
        row_end    = (col == width_last);
        load       = accept && !drop;

        if (final_item)
            item.kind = sobel_pkg::KIND_FINAL;
        else if (flushing)
            item.kind = sobel_pkg::KIND_FLUSH;
        else if (row_reg == '0)
            item.kind = sobel_pkg::KIND_FIRST;
        else
            item.kind = sobel_pkg::KIND_INNER;

        item.emit_prev = !final_item && (col == '0) && (row_reg >= sobel_pkg::ROW_W'(2));
        item.emit_cur  = !final_item && (col != '0) && (row_reg != '0);
        item.wide      = (width_last != '0);
        item.col_ge2   = (col > COL_W'(1));
        item.pixel     = pixel_in;
    end

    // Advance the column, wrap into the next row, clear after the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (load)
        begin
            if (final_item)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + sobel_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/sobel_line_mem.sv */
// Line store memory: one write and one registered read per cycle.
module sobel_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write, and read with the same-cycle write passed straight through
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sobel_window.sv */
// Window stage: builds each new column, shifts the 3x3 window, picks neighbourhoods.
module sobel_window #(
    parameter int COL_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  sobel_pkg::item_t       item,
    input  logic [COL_W-1:0]       col,
    input  logic [2*sobel_pkg::PIX_W-1:0] rd_data,
    output logic                   ready,
    output logic                   wr_en,
    output logic [COL_W-1:0]       wr_addr,
    output logic [2*sobel_pkg::PIX_W-1:0] wr_data,
    output logic                   win_valid,
    output sobel_pkg::win_item_t   win_item,
    input  logic                   win_ready
);

    logic                    s1_valid_reg;
    sobel_pkg::item_t        s1_item_reg;
    logic [COL_W-1:0]        s1_col_reg;
    sobel_pkg::col_t         win_reg [sobel_pkg::KERNEL];
    logic                    s2_valid_reg;
    sobel_pkg::win_item_t    s2_item_reg;

    sobel_pkg::line_pair_t   pair;
    sobel_pkg::line_pair_t   pair_next;
    sobel_pkg::col_t         v;
    sobel_pkg::win_item_t    sel;
    logic                    push;
    logic                    store;
    logic                    emit;
    logic                    s1_go;
    logic                    s2_free;

    // Form the incoming column and the line store update
    always_comb
    begin
        pair      = sobel_pkg::line_pair_t'(rd_data);
        pair_next = pair;
        v         = '0;
        push      = 1'b1;
        store     = 1'b0;
        case (s1_item_reg.kind)
            sobel_pkg::KIND_FIRST:
            begin
                v         = {s1_item_reg.pixel, s1_item_reg.pixel, s1_item_reg.pixel};
                pair_next = '{older: s1_item_reg.pixel, newer: s1_item_reg.pixel};
                store     = 1'b1;
            end
            sobel_pkg::KIND_INNER:
            begin
                v         = {s1_item_reg.pixel, pair.newer, pair.older};
                pair_next = '{older: pair.newer, newer: s1_item_reg.pixel};
                store     = 1'b1;
            end
            sobel_pkg::KIND_FLUSH:
            begin
                v = {pair.newer, pair.newer, pair.older};
            end
            sobel_pkg::KIND_FINAL:
            begin
                push = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Pick the neighbourhood; row ends replicate the rightmost column
    always_comb
    begin
        emit = (s1_item_reg.kind == sobel_pkg::KIND_FINAL)
            || s1_item_reg.emit_prev || s1_item_reg.emit_cur;
        if (s1_item_reg.emit_cur)
        begin
            sel.left  = s1_item_reg.col_ge2 ? win_reg[1] : win_reg[2];
            sel.mid   = win_reg[2];
            sel.right = v;
        end
        else
        begin
            sel.left  = s1_item_reg.wide ? win_reg[1] : win_reg[2];
            sel.mid   = win_reg[2];
            sel.right = win_reg[2];
        end
        sel.last = (s1_item_reg.kind == sobel_pkg::KIND_FINAL);
    end

    // Handshake between the two stages
    assign s2_free = !s2_valid_reg || win_ready;
    assign s1_go   = s1_valid_reg && (!emit || s2_free);
    assign ready   = !s1_valid_reg || s1_go;

    assign wr_en   = s1_go && store;
    assign wr_addr = s1_col_reg;
    assign wr_data = pair_next;

    // Hold the decoded request and its column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ready)
            s1_valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            s1_item_reg <= item;
            s1_col_reg  <= col;
        end
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sobel_pkg::KERNEL; i++)
                win_reg[i] <= '0;
        end
        else if (s1_go && push)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= v;
        end
    end

    // Register the neighbourhood for the gradient stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_go && emit;
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_go && emit)
            s2_item_reg <= sel;
    end

    assign win_valid = s2_valid_reg;
    assign win_item  = s2_item_reg;

endmodule

/* rtl/sobel_grad.sv */
// Gradient stages: Sobel sums, magnitudes, squares and the threshold compare.
module sobel_grad (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              win_valid,
    input  sobel_pkg::win_item_t              win_item,
    output logic                              win_ready,
    input  logic [sobel_pkg::THR_SQ_W-1:0]    thr_sq,
    sobel_res_if.source                       res
);

    localparam int SUM_W = sobel_pkg::PIX_W + 2;

    logic                                  s3_valid_reg;
    logic [sobel_pkg::PIX_W-1:0]           ax_reg;
    logic [sobel_pkg::PIX_W-1:0]           ay_reg;
    logic                                  s3_last_reg;
    logic                                  s4_valid_reg;
    logic [sobel_pkg::THR_SQ_W-1:0]        sqx_reg;
    logic [sobel_pkg::THR_SQ_W-1:0]        sqy_reg;
    logic                                  s4_last_reg;
    logic                                  out_valid_reg;
    logic [sobel_pkg::PIX_W-1:0]           edge_reg;
    logic                                  last_reg;

    logic [sobel_pkg::PIX_W-1:0]           ax;
    logic [sobel_pkg::PIX_W-1:0]           ay;
    logic [sobel_pkg::THR_SQ_W:0]          mag_sq;
    logic                                  out_take;
    logic                                  s4_free;
    logic                                  s3_free;

    // Weighted tap sum a + 2b + c
    function automatic logic [SUM_W-1:0] tap_sum(
        input logic [sobel_pkg::PIX_W-1:0] a,
        input logic [sobel_pkg::PIX_W-1:0] b,
        input logic [sobel_pkg::PIX_W-1:0] c
    );
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // Absolute difference divided by four, half rounded up
    function automatic logic [sobel_pkg::PIX_W-1:0] mag_part(
        input logic [SUM_W-1:0] pos,
        input logic [SUM_W-1:0] neg
    );
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] r;
        a = (pos >= neg) ? (pos - neg) : (neg - pos);
        r = a + SUM_W'(2);
        return r[SUM_W-1:2];
    endfunction

    // Horizontal and vertical gradient magnitudes
    always_comb
    begin
        ax = mag_part(tap_sum(win_item.left[0], win_item.left[1], win_item.left[2]),
                      tap_sum(win_item.right[0], win_item.right[1], win_item.right[2]));
        ay = mag_part(tap_sum(win_item.left[0], win_item.mid[0], win_item.right[0]),
                      tap_sum(win_item.left[2], win_item.mid[2], win_item.right[2]));
        mag_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    // Stage handshake, filling bubbles ahead of a stalled result
    assign out_take  = !out_valid_reg || res.ready;
    assign s4_free   = !s4_valid_reg || out_take;
    assign s3_free   = !s3_valid_reg || s4_free;
    assign win_ready = s3_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_free)
                s3_valid_reg <= win_valid;
            if (s4_free)
                s4_valid_reg <= s3_valid_reg;
            if (out_take)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // Magnitudes, squares, then the threshold decision
    always_ff @(posedge clk)
    begin
        if (s3_free && win_valid)
        begin
            ax_reg      <= ax;
            ay_reg      <= ay;
            s3_last_reg <= win_item.last;
        end
        if (s4_free && s3_valid_reg)
        begin
            sqx_reg     <= {{sobel_pkg::PIX_W{1'b0}}, ax_reg}
                         * {{sobel_pkg::PIX_W{1'b0}}, ax_reg};
            sqy_reg     <= {{sobel_pkg::PIX_W{1'b0}}, ay_reg}
                         * {{sobel_pkg::PIX_W{1'b0}}, ay_reg};
            s4_last_reg <= s3_last_reg;
        end
        if (out_take && s4_valid_reg)
        begin
            edge_reg <= (mag_sq >= {1'b0, thr_sq}) ? sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
            last_reg <= s4_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.edge_out   = edge_reg;
    assign res.frame_last = last_reg;

endmodule

/* rtl/sobel_edge_threshold.sv */
// Sobel edge detector with threshold over a streamed grayscale frame.
//
// Usage: pixels of one frame enter on pix in raster order (action 0), then
// frame_width+1 flush requests (action 1) drain the window. Results leave on
// res in raster order, 255 for an edge pixel and 0 otherwise, with
// frame_last marking the frame's final pixel. A flush request arriving in
// the pixel part of a frame is taken and dropped.
// Throughput: one request per cycle while pix.ready is high. Results pass
// the window, magnitude, square and output registers; each pixel's result is
// completed frame_width+1 requests after the pixel. The line stores are one
// dual-ported memory, read as a request is taken and written one stage
// later, with a same-address write passed through. The user must write the
// configuration (width, height, threshold) between frames; the block does
// not enforce it. Reset clears the counters, the window and the pipeline
// valid flags and loads 640 x 480 with threshold 128; the line memory is not
// cleared. When res stalls, the stages behind it keep filling until none is
// empty, then pix.ready drops until a result is taken.
module sobel_edge_threshold #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
    sobel_pix_if.sink                           pix,
    sobel_res_if.source                         res
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_RST = (sobel_pkg::FRAME_WIDTH_RST > MAX_WIDTH)
                         ? MAX_WIDTH : sobel_pkg::FRAME_WIDTH_RST;
    localparam logic [COL_W-1:0] WLAST_RST = COL_W'(W_RST - 1);
    localparam logic [sobel_pkg::FH_W-1:0] HEIGHT_RST =
        sobel_pkg::FH_W'(sobel_pkg::FRAME_HEIGHT_RST);
    localparam logic [sobel_pkg::THR_SQ_W-1:0] THR_SQ_RST =
        sobel_pkg::THR_SQ_W'(sobel_pkg::EDGE_THRESHOLD_RST * sobel_pkg::EDGE_THRESHOLD_RST);

    logic [COL_W-1:0]                    width_last_reg;
    logic [COL_W-1:0]                    width_last_next;
    logic [sobel_pkg::FH_W-1:0]          height_reg;
    logic [sobel_pkg::FH_W-1:0]          height_next;
    logic [sobel_pkg::THR_SQ_W-1:0]      thr_sq_reg;
    logic [sobel_pkg::THR_SQ_W-1:0]      thr_sq_next;

    logic [sobel_pkg::FW_W-1:0]          fw;
    logic [sobel_pkg::FH_W-1:0]          fh;
    logic [sobel_pkg::THR_W-1:0]         thr;

    logic                                accept;
    logic                                load;
    logic [COL_W-1:0]                    col;
    sobel_pkg::item_t                    item;
    logic                                wr_en;
    logic [COL_W-1:0]                    wr_addr;
    logic [2*sobel_pkg::PIX_W-1:0]       wr_data;
    logic [2*sobel_pkg::PIX_W-1:0]       rd_data;
    logic                                win_valid;
    logic                                win_ready;
    sobel_pkg::win_item_t                win_item;

    // Clamp register writes to the supported range
    always_comb
    begin
        fw  = cfg_data[sobel_pkg::FW_W-1:0];
        fh  = cfg_data[sobel_pkg::FH_W-1:0];
        thr = cfg_data[sobel_pkg::THR_W-1:0];

        width_last_next = width_last_reg;
        height_next     = height_reg;
        thr_sq_next     = thr_sq_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                sobel_pkg::CFG_FRAME_WIDTH:
                begin
                    if (fw == '0)
                        width_last_next = '0;
                    else if (32'(fw) >= MAX_WIDTH)
                        width_last_next = COL_W'(MAX_WIDTH - 1);
                    else
                        width_last_next = COL_W'(fw - sobel_pkg::FW_W'(1));
                end
                sobel_pkg::CFG_FRAME_HEIGHT:
                begin
                    height_next = (fh == '0) ? sobel_pkg::FH_W'(1) : fh;
                end
                sobel_pkg::CFG_EDGE_THRESHOLD:
                begin
                    thr_sq_next = {{sobel_pkg::THR_W{1'b0}}, thr}
                                * {{sobel_pkg::THR_W{1'b0}}, thr};
                end
                default:
                begin
                    thr_sq_next = thr_sq_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg <= WLAST_RST;
            height_reg     <= HEIGHT_RST;
            thr_sq_reg     <= THR_SQ_RST;
        end
        else
        begin
            width_last_reg <= width_last_next;
            height_reg     <= height_next;
            thr_sq_reg     <= thr_sq_next;
        end
    end

    assign accept = pix.valid && pix.ready;

    sobel_ctrl #(
        .COL_W (COL_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (pix.action),
        .pixel_in   (pix.pixel_in),
        .width_last (width_last_reg),
        .height     (height_reg),
        .load       (load),
        .col        (col),
        .item       (item)
    );

    sobel_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (2 * sobel_pkg::PIX_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (load),
        .rd_addr (col),
        .rd_data (rd_data)
    );

    sobel_window #(
        .COL_W (COL_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .item      (item),
        .col       (col),
        .rd_data   (rd_data),
        .ready     (pix.ready),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .win_valid (win_valid),
        .win_item  (win_item),
        .win_ready (win_ready)
    );

    sobel_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_item  (win_item),
        .win_ready (win_ready),
        .thr_sq    (thr_sq_reg),
        .res       (res)
    );

endmodule

/* rtl/sobel_chk.sv */
// Port checker for the Sobel edge threshold block, bound to the top level.
module sobel_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_ready,
    input  logic                        res_valid,
    input  logic                        res_ready,
    input  logic [sobel_pkg::PIX_W-1:0] edge_out,
    input  logic                        frame_last
);

    // Hold a stalled result unchanged until it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(edge_out) && $stable(frame_last))
        else $error("stalled result changed or vanished");

    // Drive only the two result codes
    a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (edge_out == sobel_pkg::EDGE_ON) || (edge_out == sobel_pkg::EDGE_OFF))
        else $error("edge result is neither edge nor background");

    // Drop any result while in reset
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // Take a request whenever the output side is free to move
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid || res_ready) |-> pix_ready)
        else $error("request refused while the output is free");

endmodule

bind sobel_edge_threshold sobel_chk u_sobel_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pix.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .edge_out   (res.edge_out),
    .frame_last (res.frame_last)
);

/* tb/sobel_edge_threshold_test.sv */
// Self-checking testbench of the Sobel edge threshold block, with its own edge predictor.
`timescale 1ns / 100ps

module sobel_edge_threshold_test;

    localparam int LINE_MAX       = 1024;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1000;

    // Request kinds on the pixel channel
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum int {
        PAT_NOISE,
        PAT_BINARY,
        PAT_SOFT,
        PAT_RAMP
    } pattern_t;

    // Predicts the edge map of the streamed frame and checks the results against it
    class edge_tracker;
        typedef struct packed {
            sobel_pkg::pix_t level;
            logic            last;
        } edge_result_t;

        int unsigned     frame_width;
        int unsigned     frame_height;
        int unsigned     edge_threshold;
        sobel_pkg::pix_t older_row [LINE_MAX];
        sobel_pkg::pix_t newer_row [LINE_MAX];
        sobel_pkg::col_t win [3];           // index 2 is the newest column
        int unsigned     in_column;
        int unsigned     in_row;
        edge_result_t    expected_edges [$];
        int unsigned     mismatches;
        int unsigned     results_checked;
        int unsigned     requests_taken;
        int unsigned     dropped_flushes;
        int unsigned     frames_closed;

        function new();
            frame_width    = sobel_pkg::FRAME_WIDTH_RST;
            frame_height   = sobel_pkg::FRAME_HEIGHT_RST;
            edge_threshold = sobel_pkg::EDGE_THRESHOLD_RST;
            foreach (older_row[i]) older_row[i] = '0;
            foreach (newer_row[i]) newer_row[i] = '0;
            foreach (win[i]) win[i] = '0;
            in_column       = 0;
            in_row          = 0;
            mismatches      = 0;
            results_checked = 0;
            requests_taken  = 0;
            dropped_flushes = 0;
            frames_closed   = 0;
        endfunction

        function void write_register(logic [sobel_pkg::CFG_IDX_W-1:0] index,
                                     int unsigned value);
            case (index)
                sobel_pkg::CFG_FRAME_WIDTH:    frame_width    = value & 32'h7FF;
                sobel_pkg::CFG_FRAME_HEIGHT:   frame_height   = value & 32'hFFF;
                sobel_pkg::CFG_EDGE_THRESHOLD: edge_threshold = value & 32'hFF;
                default: ;
            endcase
        endfunction

        function int unsigned quarter_mag(int g);
            int unsigned a;
            a = (g < 0) ? -g : g;
            return (a + 2) >> 2;
        endfunction

        // Form both Sobel sums over one neighbourhood and queue the verdict
        function void push_edge_verdict(sobel_pkg::col_t l, sobel_pkg::col_t c,
                                        sobel_pkg::col_t r, logic last);
            int           gx;
            int           gy;
            int unsigned  ax;
            int unsigned  ay;
            edge_result_t verdict;
            gx = (int'(l[0]) + 2 * int'(l[1]) + int'(l[2]))
               - (int'(r[0]) + 2 * int'(r[1]) + int'(r[2]));
            gy = (int'(l[0]) + 2 * int'(c[0]) + int'(r[0]))
               - (int'(l[2]) + 2 * int'(c[2]) + int'(r[2]));
            ax = quarter_mag(gx);
            ay = quarter_mag(gy);
            verdict.level = (ax * ax + ay * ay >= edge_threshold * edge_threshold)
                          ? sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
            verdict.last  = last;
            expected_edges.push_back(verdict);
        endfunction

        // Advance the window by one accepted request
        function void take_pixel_request(logic act, sobel_pkg::pix_t px);
            int unsigned     w;
            int unsigned     h;
            int unsigned     col;
            bit              flushing;
            sobel_pkg::col_t v;
            w = frame_width;
            if (w == 0) w = 1;
            if (w > LINE_MAX) w = LINE_MAX;
            h = (frame_height == 0) ? 1 : frame_height;
            flushing = (in_row >= h);

            // drop a flush request that arrives among the pixels
            if (!flushing && act == ACT_FLUSH)
            begin
                dropped_flushes++;
                return;
            end
            requests_taken++;

            // close the frame with its last pixel
            if (flushing && in_row > h)
            begin
                push_edge_verdict(w >= 2 ? win[1] : win[2], win[2], win[2], 1'b1);
                in_column = 0;
                in_row    = 0;
                frames_closed++;
                return;
            end

            col = (in_column >= w) ? w - 1 : in_column;

            // the previous row's last pixel, right edge replicated
            if (col == 0 && in_row >= 2)
                push_edge_verdict(w >= 2 ? win[1] : win[2], win[2], win[2], 1'b0);

            if (flushing)
            begin
                v[0] = older_row[col];
                v[1] = newer_row[col];
                v[2] = newer_row[col];
            end
            else if (in_row == 0)
            begin
                v[0] = px;
                v[1] = px;
                v[2] = px;
                older_row[col] = px;
                newer_row[col] = px;
            end
            else
            begin
                v[0] = older_row[col];
                v[1] = newer_row[col];
                v[2] = px;
                older_row[col] = newer_row[col];
                newer_row[col] = px;
            end
            win[0] = win[1];
            win[1] = win[2];
            win[2] = v;

            if (col >= 1 && in_row >= 1)
                push_edge_verdict(col >= 2 ? win[0] : win[1], win[1], win[2], 1'b0);

            if (col >= w - 1)
            begin
                in_column = 0;
                in_row    = (in_row + 1) & 32'h1FFF;
            end
            else
            begin
                in_column = (col + 1) & 32'h3FF;
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t ns mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Compare one taken result with the oldest expected edge
        task check_edge(sobel_pkg::pix_t level, logic last);
            edge_result_t want;
            results_checked++;
            if (expected_edges.size() == 0)
            begin
                report_mismatch($sformatf("result %0d (edge_out %0d, frame_last %0b) not expected",
                                          results_checked, level, last));
                return;
            end
            want = expected_edges.pop_front();
            if (level !== want.level)
                report_mismatch($sformatf("result %0d: edge_out %0d, want %0d",
                                          results_checked, level, want.level));
            if (last !== want.last)
                report_mismatch($sformatf("result %0d: frame_last %0b, want %0b",
                                          results_checked, last, want.last));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data;

    sobel_pix_if pix_bus ();
    sobel_res_if res_bus ();

    edge_tracker tracker = new();

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_granted;

    sobel_edge_threshold #(
        .MAX_WIDTH (LINE_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_bus),
        .res       (res_bus)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count sender idle cycles ahead of the next request
    function automatic int unsigned source_gap();
        int unsigned n;
        n = 0;
        while ($urandom_range(99) < src_idle_pct) n++;
        return n;
    endfunction

    function automatic sobel_pkg::pix_t pattern_pixel(pattern_t pat, int unsigned r,
                                                      int unsigned c);
        case (pat)
            PAT_BINARY: return $urandom_range(1) ? 8'd255 : 8'd0;
            PAT_SOFT:   return sobel_pkg::pix_t'(120 + $urandom_range(15));
            PAT_RAMP:   return sobel_pkg::pix_t'(c * 37 + r * 11);
            default:    return sobel_pkg::pix_t'($urandom_range(255));
        endcase
    endfunction

    // Offer one request and hold it until taken; called and left at a falling edge
    task automatic offer_request(logic act, sobel_pkg::pix_t px);
        int unsigned gap;
        pix_bus.valid    <= 1'b1;
        pix_bus.action   <= act;
        pix_bus.pixel_in <= px;
        do @(posedge clk); while (pix_bus.ready !== 1'b1);
        tracker.take_pixel_request(act, px);
        @(negedge clk);
        gap = source_gap();
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Write all three registers on consecutive cycles
    task automatic configure(int unsigned w, int unsigned h, int unsigned thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= sobel_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= sobel_pkg::CFG_DATA_W'(w);
        @(negedge clk);
        cfg_index <= sobel_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= sobel_pkg::CFG_DATA_W'(h);
        @(negedge clk);
        cfg_index <= sobel_pkg::CFG_EDGE_THRESHOLD;
        cfg_data  <= sobel_pkg::CFG_DATA_W'(thr);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.write_register(sobel_pkg::CFG_FRAME_WIDTH, w);
        tracker.write_register(sobel_pkg::CFG_FRAME_HEIGHT, h);
        tracker.write_register(sobel_pkg::CFG_EDGE_THRESHOLD, thr);
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        while (tracker.expected_edges.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Stream one whole frame with some dropped flushes and late pixels mixed in
    task automatic send_frame(int unsigned w, int unsigned h, int unsigned thr,
                              pattern_t pat, bit squeeze);
        int unsigned ew;
        int unsigned eh;
        drain_results();
        configure(w, h, thr);
        ew = (w == 0) ? 1 : ((w > LINE_MAX) ? LINE_MAX : w);
        eh = (h == 0) ? 1 : h;
        if (squeeze) hold_granted++;
        for (int unsigned r = 0; r < eh; r++)
        begin
            for (int unsigned c = 0; c < ew; c++)
            begin
                if ($urandom_range(99) < 3)
                    offer_request(ACT_FLUSH, sobel_pkg::pix_t'($urandom_range(255)));
                offer_request(ACT_PIXEL, pattern_pixel(pat, r, c));
            end
        end
        for (int unsigned k = 0; k <= ew; k++)
            offer_request(($urandom_range(99) < 25) ? ACT_PIXEL : ACT_FLUSH,
                          sobel_pkg::pix_t'($urandom_range(255)));
        pix_bus.valid <= 1'b0;
    endtask

    function automatic int unsigned pick_threshold();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 255;
            2, 3:    return $urandom_range(10, 80);
            default: return $urandom_range(255);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned holds_served;
        res_bus.ready = 1'b0;
        hold_left     = 0;
        holds_served  = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_granted)
            begin
                holds_served = hold_granted;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check every taken result
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            tracker.check_edge(res_bus.edge_out, res_bus.frame_last);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin
        int unsigned random_start;
        int unsigned frame_no;
        int unsigned w;
        int unsigned h;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = sobel_pkg::CFG_FRAME_WIDTH;
        cfg_data         = '0;
        pix_bus.valid    = 1'b0;
        pix_bus.action   = ACT_PIXEL;
        pix_bus.pixel_in = '0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        hold_granted     = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Tiny frame, threshold 0: extreme pixels, a dropped flush, a late pixel
        drain_results();
        configure(3, 2, 0);
        offer_request(ACT_PIXEL, 8'd0);
        offer_request(ACT_PIXEL, 8'd255);
        offer_request(ACT_FLUSH, 8'd77);
        offer_request(ACT_PIXEL, 8'd1);
        offer_request(ACT_PIXEL, 8'd254);
        offer_request(ACT_PIXEL, 8'd128);
        offer_request(ACT_PIXEL, 8'd127);
        offer_request(ACT_FLUSH, 8'd0);
        offer_request(ACT_PIXEL, 8'd99);
        offer_request(ACT_FLUSH, 8'd255);
        offer_request(ACT_FLUSH, 8'd0);
        pix_bus.valid <= 1'b0;

        // Width and height of zero act as one; the closing request is a pixel
        drain_results();
        configure(0, 0, 255);
        offer_request(ACT_PIXEL, 8'd200);
        offer_request(ACT_FLUSH, 8'd0);
        offer_request(ACT_PIXEL, 8'd31);
        pix_bus.valid <= 1'b0;

        // Two pixels wide checkerboard at the top threshold
        drain_results();
        configure(2, 3, 255);
        offer_request(ACT_PIXEL, 8'd0);
        offer_request(ACT_PIXEL, 8'd255);
        offer_request(ACT_PIXEL, 8'd255);
        offer_request(ACT_PIXEL, 8'd0);
        offer_request(ACT_PIXEL, 8'd0);
        offer_request(ACT_PIXEL, 8'd255);
        offer_request(ACT_FLUSH, 8'd0);
        offer_request(ACT_FLUSH, 8'd0);
        offer_request(ACT_FLUSH, 8'd0);
        pix_bus.valid <= 1'b0;

        // Hold the receiver off so the block fills and stalls its input
        send_frame(16, 8, 60, PAT_NOISE, 1'b1);

        // Random frames, rotating through the idling phases
        random_start = tracker.requests_taken;
        frame_no     = 0;
        while (tracker.requests_taken < random_start + RANDOM_ITEMS)
        begin
            case (frame_no % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 48;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 48;
                end
                default:
                begin
                    src_idle_pct  = 10;
                    snk_stall_pct = 10;
                end
            endcase
            w = ($urandom_range(3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            h = ($urandom_range(3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            send_frame(w, h, pick_threshold(), pattern_t'($urandom_range(3)), 1'b0);
            frame_no++;
        end

        // Tall single-column frame with a binary pattern
        src_idle_pct  = 10;
        snk_stall_pct = 10;
        send_frame(1, 150, 30, PAT_BINARY, 1'b0);

        drain_results();
        $display("run covered %0d frames: %0d requests taken, %0d flush requests dropped",
                 tracker.frames_closed, tracker.requests_taken, tracker.dropped_flushes);
        $display("checked %0d edge results, %0d mismatches",
                 tracker.results_checked, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
